// ----- src/met_pkg.sv -----
`timescale 1ns / 1ps

package met_pkg;

  typedef struct packed {
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
  } point_t;

  typedef struct packed {
    logic [15:0] iterations;
    logic        inside_res;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } result_t;

  typedef logic [15:0] cfg_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EVAL
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic finish;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic first;
    logic near_origin;
    logic escaped;
    logic at_limit;
  } dp_sts_t;

  localparam logic [31:0] MAX_ITER_RESET = 32'd10000;
  localparam logic [7:0]  RED_HIGH       = 8'd240;

endpackage

// ----- src/met_stream_if.sv -----
`timescale 1ns / 1ps

interface met_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/met_ctrl.sv -----
`timescale 1ns / 1ps

module met_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  met_pkg::dp_sts_t  sts_i,
  output met_pkg::ctl_cmd_t cmd_o
);

  met_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic done, out_free;

  assign done     = (sts_i.first & sts_i.near_origin) | sts_i.at_limit | sts_i.escaped;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      met_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = met_pkg::ST_MUL;
      end
      met_pkg::ST_MUL: begin
        state_d = met_pkg::ST_EVAL;
      end
      met_pkg::ST_EVAL: begin
        if (!done) state_d = met_pkg::ST_MUL;
        else if (out_free) state_d = met_pkg::ST_IDLE;
      end
      default: state_d = met_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      met_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      met_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
      end
      met_pkg::ST_EVAL: begin
        cmd_o.step   = !done;
        cmd_o.finish = done && out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.finish) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= met_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("finished item not presented");

  a_mul_then_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == met_pkg::ST_MUL |=> state_q == met_pkg::ST_EVAL)
    else $error("multiply cycle not followed by evaluate");

  a_step_xor_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.step && cmd_o.finish))
    else $error("step and finish together");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == met_pkg::ST_MUL)
    else $error("accepted item did not start");

endmodule

// ----- src/met_datapath.sv -----
`timescale 1ns / 1ps

module met_datapath #(
  parameter int FRAC_BITS   = 28,
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  met_pkg::ctl_cmd_t  cmd_i,
  output met_pkg::dp_sts_t   sts_o,
  input  met_pkg::point_t    point_i,
  input  logic               cfg_valid_i,
  input  met_pkg::cfg_word_t cfg_data_i,
  output met_pkg::result_t   result_o
);

  // magnitude bits of z: |c| <= 2^31 plus up to 4.0 added
  localparam int MW = ((FRAC_BITS + 2 > 31) ? FRAC_BITS + 2 : 31) + 1;
  localparam int XW = MW + 1;
  localparam int PW = 2 * MW;
  localparam int SW = PW - FRAC_BITS;
  localparam logic [SW:0] SIXTEENTH = {{SW{1'b0}}, 1'b1} << (FRAC_BITS - 4);
  localparam logic [SW:0] FOUR      = {{SW{1'b0}}, 1'b1} << (FRAC_BITS + 2);

  logic signed [XW-1:0] x_q, y_q, cr_q, ci_q;
  logic signed [XW-1:0] x_d, y_d;
  logic [PW-1:0] pxx_q, pyy_q, pxy_q;
  logic          neg_q;
  logic          first_q;
  logic [COUNT_WIDTH-1:0] count_q, max_q, max_d;
  met_pkg::result_t res_q, res_d;

  logic [XW-1:0] x_neg, y_neg;
  logic [MW-1:0] x_mag, y_mag;
  logic [SW-1:0] r2, i2;
  logic [SW:0]   sum;
  logic [PW-FRAC_BITS:0] xy2_full;
  logic signed [XW-1:0]  xy2, xy2_s;
  logic [COUNT_WIDTH-1:0] fc;
  logic [31:0] fc_ext, cfg_ext;
  logic [7:0]  shade;
  logic        is_inside;

  assign x_neg = -x_q;
  assign y_neg = -y_q;
  assign x_mag = x_q[XW-1] ? x_neg[MW-1:0] : x_q[MW-1:0];
  assign y_mag = y_q[XW-1] ? y_neg[MW-1:0] : y_q[MW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      pxx_q <= x_mag * x_mag;
      pyy_q <= y_mag * y_mag;
      pxy_q <= x_mag * y_mag;
      neg_q <= x_q[XW-1] ^ y_q[XW-1];
    end
  end

  assign r2       = pxx_q[PW-1:FRAC_BITS];
  assign i2       = pyy_q[PW-1:FRAC_BITS];
  assign sum      = {1'b0, r2} + {1'b0, i2};
  assign xy2_full = pxy_q[PW-1:FRAC_BITS-1];
  assign xy2      = xy2_full[XW-1:0];
  assign xy2_s    = neg_q ? -xy2 : xy2;

  assign y_d = xy2_s + ci_q;
  assign x_d = r2[XW-1:0] - i2[XW-1:0] + cr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q     <= {{(XW-32){point_i.c_real[31]}}, point_i.c_real};
      y_q     <= {{(XW-32){point_i.c_imag[31]}}, point_i.c_imag};
      cr_q    <= {{(XW-32){point_i.c_real[31]}}, point_i.c_real};
      ci_q    <= {{(XW-32){point_i.c_imag[31]}}, point_i.c_imag};
      count_q <= COUNT_WIDTH'(1);
    end else if (cmd_i.step) begin
      x_q     <= x_d;
      y_q     <= y_d;
      count_q <= count_q + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b0;
    end else if (cmd_i.load) begin
      first_q <= 1'b1;
    end else if (cmd_i.step) begin
      first_q <= 1'b0;
    end
  end

  assign sts_o.first       = first_q;
  assign sts_o.near_origin = sum < SIXTEENTH;
  assign sts_o.escaped     = sum > FOUR;
  assign sts_o.at_limit    = !(count_q < max_q);

  assign cfg_ext = {16'b0, cfg_data_i};
  assign max_d   = cfg_ext[COUNT_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= met_pkg::MAX_ITER_RESET[COUNT_WIDTH-1:0];
    end else if (cfg_valid_i) begin
      max_q <= max_d;
    end
  end

  // result coloring
  assign fc        = (first_q && sts_o.near_origin) ? max_q : count_q;
  assign is_inside = (fc == max_q);
  assign fc_ext    = 32'(fc);
  assign shade     = {fc[3:0], 4'b0000};

  always_comb begin
    res_d            = '0;
    res_d.iterations = fc_ext[15:0];
    res_d.inside_res = is_inside;
    if (!is_inside) begin
      if (fc[4]) begin
        res_d.red   = met_pkg::RED_HIGH;
        res_d.green = shade;
        res_d.blue  = shade;
      end else begin
        res_d.red = shade;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) res_q <= res_d;
  end

  assign result_o = res_q;

endmodule

// ----- src/mandelbrot_escape_time_core.sv -----
`timescale 1ns / 1ps
// Mandelbrot escape-time core.
// point_i (sink): one complex point c per item, c_real and c_imag in signed
//   fixed point with FRAC_BITS fraction bits.
// result_o (source): one item per point: escape count, inside flag and RGB.
// cfg_i (sink): writes max_iterations; always ready, write only while idle.
// Timing: an accepted point is loaded in the input state; each pass then
//   runs a multiply state and an evaluate state (three parallel multiplies
//   into registers, then shift, sum, escape compare and z update). A point
//   with final count n makes n passes, at most max(max_iterations, 1);
//   points near the origin finish at the first evaluate. Throughput is
//   bounded by this multiply/update loop; one point is worked on at a time.
// The result sits in an output register, so the next point is accepted while
//   a finished result waits. If the receiver stalls while a second point is
//   done, that point holds in its evaluate state until the register frees.
// Reset: asynchronous active low; clears the handshake state and restores
//   max_iterations to 10000 (masked to COUNT_WIDTH bits).
module mandelbrot_escape_time_core #(
  parameter int FRAC_BITS   = 28,
  parameter int COUNT_WIDTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  met_stream_if.sink   point_i,
  met_stream_if.source result_o,
  met_stream_if.sink   cfg_i
);

  met_pkg::ctl_cmd_t cmd;
  met_pkg::dp_sts_t  sts;
  met_pkg::point_t   point;
  met_pkg::result_t  result;
  logic              in_ready, out_valid;

  assign point         = point_i.data;
  assign point_i.ready = in_ready;
  assign result_o.valid = out_valid;
  assign result_o.data  = result;
  assign cfg_i.ready    = 1'b1;

  met_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (point_i.valid),
    .in_ready_o  (in_ready),
    .out_ready_i (result_o.ready),
    .out_valid_o (out_valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  met_datapath #(
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .point_i     (point),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .result_o    (result)
  );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int FRAC_BITS      = 28;
  localparam int COUNT_WIDTH    = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 15;

  localparam longint ESCAPE_RADIUS2 = longint'(4) <<< FRAC_BITS;
  localparam longint ORIGIN_RADIUS2 = longint'(1) <<< (FRAC_BITS - 4);

  localparam logic signed [31:0] FX_MIN     = 32'sh8000_0000;
  localparam logic signed [31:0] FX_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] FX_ONE     = 32'sh1000_0000;
  localparam logic signed [31:0] FX_TWO     = 32'sh2000_0000;
  localparam logic signed [31:0] FX_HALF    = 32'sh0800_0000;
  localparam logic signed [31:0] FX_QUARTER = 32'sh0400_0000;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_POINT,
    ROW_TYPED
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    met_pkg::cfg_word_t limit;
    met_pkg::point_t    pt;
    met_pkg::result_t   res;
  } dir_row_t;

  localparam met_pkg::point_t  NO_POINT   = '0;
  localparam met_pkg::result_t NO_RESULT  = '0;
  localparam met_pkg::result_t FIRST_PASS = '{16'd1, 1'b0, 8'd16, 8'd0, 8'd0};

  localparam int N_DIR = 27;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{ROW_TYPED, 16'd0, '{32'sd0, 32'sd0}, '{16'd10000, 1'b1, 8'd0, 8'd0, 8'd0}},
    '{ROW_TYPED, 16'd0, '{FX_TWO, FX_TWO}, FIRST_PASS},
    '{ROW_TYPED, 16'd0, '{FX_MIN, FX_MIN}, FIRST_PASS},
    '{ROW_TYPED, 16'd0, '{FX_MAX, FX_MAX}, FIRST_PASS},
    '{ROW_TYPED, 16'd0, '{FX_MAX, FX_MIN}, FIRST_PASS},
    // |c|^2 exactly 1/16: not near origin
    '{ROW_POINT, 16'd0, '{FX_QUARTER, 32'sd0}, NO_RESULT},
    '{ROW_TYPED, 16'd0, '{32'sh03FF_FFFF, 32'sd0}, '{16'd10000, 1'b1, 8'd0, 8'd0, 8'd0}},
    '{ROW_TYPED, 16'd0, '{32'sd0, 32'shFC00_0001}, '{16'd10000, 1'b1, 8'd0, 8'd0, 8'd0}},
    // |z|^2 sits at exactly 4 forever
    '{ROW_POINT, 16'd0, '{32'shE000_0000, 32'sd0}, NO_RESULT},
    '{ROW_TYPED, 16'd0, '{FX_TWO, 32'sd0}, '{16'd2, 1'b0, 8'd32, 8'd0, 8'd0}},
    '{ROW_POINT, 16'd0, '{32'sd0, FX_ONE}, NO_RESULT},
    '{ROW_CFG, 16'd65535, NO_POINT, NO_RESULT},
    '{ROW_TYPED, 16'd0, '{32'sd0, 32'sd0}, '{16'd65535, 1'b1, 8'd0, 8'd0, 8'd0}},
    '{ROW_POINT, 16'd0, '{32'shF000_0000, 32'sd0}, NO_RESULT},
    '{ROW_POINT, 16'd0, '{FX_HALF, FX_HALF}, NO_RESULT},
    '{ROW_CFG, 16'd2, NO_POINT, NO_RESULT},
    '{ROW_TYPED, 16'd0, '{32'shF800_0000, 32'sd0}, '{16'd2, 1'b1, 8'd0, 8'd0, 8'd0}},
    '{ROW_TYPED, 16'd0, '{FX_MAX, 32'sd0}, FIRST_PASS},
    // limit below two: z is never updated
    '{ROW_CFG, 16'd0, NO_POINT, NO_RESULT},
    '{ROW_TYPED, 16'd0, '{32'sd0, 32'sd0}, '{16'd0, 1'b1, 8'd0, 8'd0, 8'd0}},
    '{ROW_TYPED, 16'd0, '{FX_TWO, FX_TWO}, FIRST_PASS},
    '{ROW_CFG, 16'd1, NO_POINT, NO_RESULT},
    '{ROW_TYPED, 16'd0, '{32'sd0, 32'sd0}, '{16'd1, 1'b1, 8'd0, 8'd0, 8'd0}},
    '{ROW_TYPED, 16'd0, '{32'shF800_0000, 32'sd0}, '{16'd1, 1'b1, 8'd0, 8'd0, 8'd0}},
    '{ROW_CFG, 16'd40, NO_POINT, NO_RESULT},
    '{ROW_POINT, 16'd0, '{32'sd69793219, 32'sd0}, NO_RESULT},
    '{ROW_POINT, 16'd0, '{32'shF400_0000, 32'sd26843546}, NO_RESULT}
  };

  logic clk = 1'b0;
  logic rst_n;

  met_stream_if #(.payload_t(met_pkg::point_t))    point_if ();
  met_stream_if #(.payload_t(met_pkg::result_t))   result_if ();
  met_stream_if #(.payload_t(met_pkg::cfg_word_t)) cfg_if ();

  mandelbrot_escape_time_core #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .point_i (point_if),
    .result_o(result_if),
    .cfg_i   (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  met_pkg::cfg_word_t iter_limit = met_pkg::cfg_word_t'(met_pkg::MAX_ITER_RESET);
  met_pkg::result_t   expected_escapes [$];
  bit        steady   = 1'b0;
  bit        hold_req = 1'b0;
  int        error_count     = 0;
  int        points_sent     = 0;
  int        results_checked = 0;
  int        limit_writes    = 0;
  int        quiet_cycles    = 0;

  task automatic flag_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // magnitudes multiplied exactly, truncated toward zero, sign applied last
  function automatic longint scaled_product(longint a, longint b, int sh);
    logic [63:0]  ma, mb, mag;
    logic [127:0] prod;
    ma   = (a < 0) ? 64'(-a) : 64'(a);
    mb   = (b < 0) ? 64'(-b) : 64'(b);
    prod = {64'd0, ma} * {64'd0, mb};
    mag  = 64'(prod >> sh);
    return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic met_pkg::result_t predict_escape(met_pkg::point_t p);
    longint           cr, ci, x, y, re2, im2, xy2;
    int unsigned      count;
    logic [7:0]       shade;
    met_pkg::result_t r;
    cr    = longint'(p.c_real);
    ci    = longint'(p.c_imag);
    x     = cr;
    y     = ci;
    count = 1;
    if (scaled_product(x, x, FRAC_BITS) + scaled_product(y, y, FRAC_BITS) < ORIGIN_RADIUS2) begin
      count = iter_limit;
    end else begin
      while (count < iter_limit) begin
        re2 = scaled_product(x, x, FRAC_BITS);
        im2 = scaled_product(y, y, FRAC_BITS);
        if (re2 + im2 > ESCAPE_RADIUS2) break;
        xy2 = scaled_product(x, y, FRAC_BITS - 1);
        y = xy2 + ci;
        x = re2 - im2 + cr;
        count++;
      end
    end
    r            = '0;
    r.iterations = count[15:0];
    r.inside_res = (count == iter_limit);
    if (!r.inside_res) begin
      shade = 8'((count & 15) * 16);
      if (count[4]) begin
        r.red   = met_pkg::RED_HIGH;
        r.green = shade;
        r.blue  = shade;
      end else begin
        r.red = shade;
      end
    end
    return r;
  endfunction

  function automatic int random_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic met_pkg::point_t random_point();
    met_pkg::point_t p;
    int unsigned     mode;
    mode = $urandom_range(0, 99);
    if (mode < 45) begin
      p.c_real = $urandom_range(0, 32'h3000_0000) - 32'h2400_0000;
      p.c_imag = $urandom_range(0, 32'h3000_0000) - 32'h1800_0000;
    end else if (mode < 60) begin
      p.c_real = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      p.c_imag = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    end else if (mode < 75) begin
      p.c_real = $urandom_range(0, 32'h5000_0000) - 32'h2800_0000;
      p.c_imag = $urandom_range(0, 32'h5000_0000) - 32'h2800_0000;
    end else begin
      p.c_real = $urandom;
      p.c_imag = $urandom;
    end
    return p;
  endfunction

  // valid is left high after an item when no gap follows
  task automatic offer_point(met_pkg::point_t p, met_pkg::result_t exp);
    int gap;
    point_if.valid <= 1'b1;
    point_if.data  <= p;
    do @(posedge clk); while (!point_if.ready);
    expected_escapes.push_back(exp);
    points_sent++;
    gap = random_gap();
    if (gap > 0) begin
      point_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    point_if.valid <= 1'b0;
    while (expected_escapes.size() != 0) @(posedge clk);
  endtask

  task automatic set_limit(met_pkg::cfg_word_t v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    iter_limit = v & met_pkg::cfg_word_t'((32'd1 << COUNT_WIDTH) - 1);
    limit_writes++;
  endtask

  // result receiver
  initial begin
    int stall;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = random_gap();
        if (stall > 0) begin
          result_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      result_if.ready <= 1'b1;
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    met_pkg::result_t want;
    if (rst_n) begin
      if ((point_if.valid && point_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (result_if.valid && result_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (result_if.valid && result_if.ready) begin
        if (expected_escapes.size() == 0) begin
          flag_error($sformatf("result with no point pending, iterations %0d",
                               result_if.data.iterations));
        end else begin
          want = expected_escapes.pop_front();
          results_checked++;
          if (result_if.data.iterations !== want.iterations)
            flag_error($sformatf("iterations %0d, expected %0d",
                                 result_if.data.iterations, want.iterations));
          if (result_if.data.inside_res !== want.inside_res)
            flag_error($sformatf("inside_res %0b, expected %0b",
                                 result_if.data.inside_res, want.inside_res));
          if (result_if.data.red !== want.red)
            flag_error($sformatf("red %0d, expected %0d", result_if.data.red, want.red));
          if (result_if.data.green !== want.green)
            flag_error($sformatf("green %0d, expected %0d",
                                 result_if.data.green, want.green));
          if (result_if.data.blue !== want.blue)
            flag_error($sformatf("blue %0d, expected %0d", result_if.data.blue, want.blue));
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d cycles without a handshake", quiet_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    met_pkg::point_t    pt;
    met_pkg::cfg_word_t phase_limit;
    point_if.valid = 1'b0;
    point_if.data  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    rst_n          = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      case (DIR_ROWS[i].kind)
        ROW_CFG: begin
          wait_drained();
          set_limit(DIR_ROWS[i].limit);
        end
        ROW_POINT: offer_point(DIR_ROWS[i].pt, predict_escape(DIR_ROWS[i].pt));
        default:   offer_point(DIR_ROWS[i].pt, DIR_ROWS[i].res);
      endcase
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0:       phase_limit = met_pkg::cfg_word_t'($urandom_range(2, 40));
        1:       phase_limit = met_pkg::cfg_word_t'($urandom_range(16, 100));
        2:       phase_limit = 16'd255;
        3:       phase_limit = met_pkg::cfg_word_t'($urandom_range(2, 33));
        default: phase_limit = 16'd1000;
      endcase
      set_limit(phase_limit);
      steady = (phase == 3);
      if (phase == 1) begin
        // fast escapes while the output is held off, to back up the input
        hold_req = 1'b1;
        repeat (6) begin
          pt.c_real = 32'sh6000_0000;
          pt.c_imag = $urandom;
          offer_point(pt, predict_escape(pt));
        end
      end
      repeat (PHASE_ITEMS) begin
        pt = random_point();
        offer_point(pt, predict_escape(pt));
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_escapes.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_escapes.size()));
    $display("%0d points sent, %0d results checked, %0d limit writes (0 to 65535)",
             points_sent, results_checked, limit_writes);
    $display("covered origin and escape boundaries, field extremes and a long output stall");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
